// ===== rtl/mi_pkg.sv =====
package mi_pkg;

  localparam int MI_WIDTH = 16;
  localparam int CNT_W    = (MI_WIDTH > 1) ? $clog2(MI_WIDTH) : 1;
  localparam int PC_W     = 3;

  typedef struct packed {
    logic [MI_WIDTH-1:0] value;
    logic [MI_WIDTH-1:0] modulus;
  } mi_in_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_MOD_ZERO    = 2'd2
  } mi_status_t;

  typedef struct packed {
    logic [MI_WIDTH-1:0] inverse;
    logic [MI_WIDTH-1:0] common_divisor;
    mi_status_t          status;
  } mi_out_t;

  // Datapath operations driven by one control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_FIX,
    OP_OUT
  } mi_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_IDLE,
    JMP_ZERO,
    JMP_COUNT
  } mi_cond_t;

  typedef struct packed {
    mi_op_t          op;
    mi_cond_t        cond;
    logic [PC_W-1:0] target;
  } mi_ctrl_t;

  // Step addresses of the program
  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd2;
  localparam logic [PC_W-1:0] PC_UPDATE = 3'd3;
  localparam logic [PC_W-1:0] PC_FIX    = 3'd4;
  localparam logic [PC_W-1:0] PC_OUT    = 3'd5;

  // Control store
  function automatic mi_ctrl_t mi_ucode(input logic [PC_W-1:0] pc);
    mi_ctrl_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_LOAD,     cond: JMP_IDLE,   target: PC_WAIT};
      PC_TEST:   w = '{op: OP_DIV_INIT, cond: JMP_ZERO,   target: PC_FIX};
      PC_DIV:    w = '{op: OP_DIV_STEP, cond: JMP_COUNT,  target: PC_DIV};
      PC_UPDATE: w = '{op: OP_UPDATE,   cond: JMP_ALWAYS, target: PC_TEST};
      PC_FIX:    w = '{op: OP_FIX,      cond: JMP_NEVER,  target: PC_WAIT};
      PC_OUT:    w = '{op: OP_OUT,      cond: JMP_ALWAYS, target: PC_WAIT};
      default:   w = '{op: OP_NOP,      cond: JMP_ALWAYS, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/modular_inverse.sv =====
// Channel  | Signals              | Handshake
// ---------+----------------------+---------------------------------------------
// input    | start, busy, item    | transaction taken at an edge with start & !busy
// output   | done, result         | result valid for the single cycle done is high
//
// A transaction runs k Euclid steps (at most about 24 for 16-bit operands): each
// step is a setup step, a restoring division over all MI_WIDTH dividend bits and
// a step that rotates the remainder and coefficient registers; a fix step and an
// output step follow. The division loop repeats its DIV step once per dividend bit.
// Synchronous reset returns the program counter to the wait step and drops done.
// The receiver cannot stall; done is a one-cycle strobe.
module modular_inverse
  import mi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  mi_in_t  item,
  output logic    busy,
  output logic    done,
  output mi_out_t result
);

  // Sequencer
  logic [PC_W-1:0]  pc, pc_next;
  mi_ctrl_t         ctrl;
  logic             jump;

  // Datapath registers
  logic [MI_WIDTH-1:0] r_old, r_cur, s_old, s_cur, m;
  logic [MI_WIDTH-1:0] rem, quot, acc;
  logic [CNT_W-1:0]    cnt;
  logic                neg;

  // Division step signals
  logic [MI_WIDTH:0]   rem_sh;
  logic                ge;
  logic [MI_WIDTH:0]   rem_diff;
  logic [MI_WIDTH-1:0] acc_next;

  // Final correction and result forming
  logic [MI_WIDTH-1:0] inv_val;
  mi_status_t          st_val;

  assign ctrl = mi_ucode(pc);

  // Resolve the jump condition of the current control word
  always_comb begin
    case (ctrl.cond)
      JMP_NEVER:  jump = 1'b0;
      JMP_ALWAYS: jump = 1'b1;
      JMP_IDLE:   jump = !start;
      JMP_ZERO:   jump = (r_cur == '0);
      JMP_COUNT:  jump = (cnt != CNT_W'(MI_WIDTH - 1));
      default:    jump = 1'b1;
    endcase
  end

  // Next step: take the branch or advance
  always_comb begin
    if (jump) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != PC_WAIT);

  // Restoring division: shift in one dividend bit, subtract when it fits;
  // fold the quotient bit into q*s_cur Horner-style, MSB first
  assign rem_sh   = {rem, quot[MI_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, r_cur};
  assign ge       = (rem_sh >= {1'b0, r_cur});
  assign acc_next = {acc[MI_WIDTH-2:0], 1'b0} + (ge ? s_cur : '0);

  // Coefficient magnitude is already reduced; apply the alternating sign and form the status (zero modulus flagged)
  always_comb begin
    if (m == '0) begin
      inv_val = '0;
      st_val  = ST_MOD_ZERO;
    end else begin
      inv_val = (neg && (s_old != '0)) ? (m - s_old) : s_old;
      st_val  = (r_old == MI_WIDTH'(1)) ? ST_OK : ST_NOT_COPRIME;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (start) begin
          r_old <= item.value;
          r_cur <= item.modulus;
          m     <= item.modulus;
          s_old <= MI_WIDTH'(1);
          s_cur <= '0;
          neg   <= 1'b0;
        end
      end
      OP_DIV_INIT: begin
        rem  <= '0;
        quot <= r_old;
        acc  <= '0;
        cnt  <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= ge ? rem_diff[MI_WIDTH-1:0] : rem_sh[MI_WIDTH-1:0];
        quot <= {quot[MI_WIDTH-2:0], 1'b0};
        acc  <= acc_next;
        cnt  <= cnt + 1'b1;
      end
      OP_UPDATE: begin
        // advance the remainder and coefficient sequences one step
        r_old <= r_cur;
        r_cur <= rem;
        s_old <= s_cur;
        s_cur <= s_old + acc;
        neg   <= !neg;
      end
      OP_FIX: begin
        // s_old never exceeds m, so one subtract reduces it
        if (s_old >= m) begin
          s_old <= s_old - m;
        end
      end
      OP_OUT: begin
        result.inverse        <= inv_val;
        result.common_divisor <= r_old;
        result.status         <= st_val;
      end
      default: begin
      end
    endcase
  end

  // One-cycle strobe for the finished transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_OUT);
    end
  end

endmodule

// ===== rtl/mi_checker.sv =====
module mi_checker
  import mi_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input mi_out_t result
);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_mod_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_MOD_ZERO)) |-> (result.inverse == '0))
    else $error("zero modulus gave nonzero inverse");

  a_ok_gcd: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_OK)) |-> (result.common_divisor == MI_WIDTH'(1)))
    else $error("valid status with gcd other than one");

endmodule

bind modular_inverse mi_checker u_mi_checker (.*);
